FILE: hw/rtl/lctg_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// lctg_pkg
// Shared types and constants for the LED chaser and tone generator.
// ---------------------------------------------------------------------------
package lctg_pkg;

  localparam int unsigned LIMIT_W    = 16;
  localparam int unsigned PERIOD_W   = 8;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 8;

  localparam logic [PERIOD_W-1:0] PERIOD_MAX = 8'd255;

  localparam logic [LIMIT_W-1:0] CHASE_LIMIT_RST = 16'd300;
  localparam logic [LIMIT_W-1:0] BLINK_LIMIT_RST = 16'd1000;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CHASE_LIMIT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_LIMIT = 8'd1;

  typedef enum logic [1:0] {
    CH_START = 2'd0,
    CH_B0    = 2'd1,
    CH_B1    = 2'd2,
    CH_B2    = 2'd3
  } chase_phase_t;

  // shared by the blink and the tone machines
  typedef enum logic [1:0] {
    LV_START = 2'd0,
    LV_ON    = 2'd1,
    LV_OFF   = 2'd2
  } level_phase_t;

  typedef enum logic [2:0] {
    AD_START    = 3'd0,
    AD_WAIT     = 3'd1,
    AD_INC      = 3'd2,
    AD_INC_WAIT = 3'd3,
    AD_DEC      = 3'd4,
    AD_DEC_WAIT = 3'd5
  } adjust_phase_t;

endpackage : lctg_pkg
`default_nettype wire

FILE: hw/rtl/led_chaser_tone_generator.sv
`default_nettype none
// ---------------------------------------------------------------------------
// led_chaser_tone_generator
// Tick-driven LED chaser, blink LED and button-controlled tone generator.
// ---------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------
//  in_     | slave     | in_tvalid/tready   | in_tdata: one tick, buttons
//  out_    | master    | out_tvalid/tready  | out_tdata: LED and tone levels
//  cfg_    | slave     | cfg_valid/ready    | cfg_index, cfg_data (limits)
//
// One tick is taken per cycle while in_tready is high; its result reaches the
// output register on the next cycle. All state updates when the tick transfers.
// in_tready drops only while a result is held and out_tready is low.
// cfg_ready is always high. Reset is synchronous to clk, active low.
// ---------------------------------------------------------------------------
module led_chaser_tone_generator import lctg_pkg::*; (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_tvalid,
  output logic                   in_tready,
  input  wire  [IN_DATA_W-1:0]   in_tdata,   // [0] up_button, [1] down_button,
                                             // [2] tone_button, [7:3] zero
  output logic                   out_tvalid,
  input  wire                    out_tready,
  output logic [OUT_DATA_W-1:0]  out_tdata,  // [2:0] chase_leds, [3] blink_led,
                                             // [4] tone_out, [7:5] zero
  input  wire                    cfg_valid,
  output logic                   cfg_ready,
  input  wire  [CFG_IDX_W-1:0]   cfg_index,
  input  wire  [LIMIT_W-1:0]     cfg_data
);

  logic [LIMIT_W-1:0]    chase_limit_r;
  logic [LIMIT_W-1:0]    blink_limit_r;

  logic [LIMIT_W-1:0]    chase_count_r, chase_count_nxt;
  chase_phase_t          chase_phase_r, chase_phase_nxt;
  logic [LIMIT_W-1:0]    blink_count_r, blink_count_nxt;
  level_phase_t          blink_phase_r, blink_phase_nxt;
  logic [PERIOD_W-1:0]   tone_count_r,  tone_count_nxt;
  level_phase_t          tone_phase_r,  tone_phase_nxt;
  logic [PERIOD_W-1:0]   tone_period_r, tone_period_nxt;
  adjust_phase_t         adjust_phase_r, adjust_phase_nxt;

  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic up, down, held;
  logic in_xfer;
  logic [2:0] chase_leds;
  logic       blink_led, tone_out;

  assign up   = in_tdata[0];
  assign down = in_tdata[1];
  assign held = in_tdata[2];

  assign in_tready  = !out_valid_r || out_tready;
  assign in_xfer    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign cfg_ready  = 1'b1;

  always_comb begin
    // chaser
    if (chase_count_r < chase_limit_r) begin
      chase_count_nxt = chase_count_r + 1'b1;
      chase_phase_nxt = chase_phase_r;
    end else begin
      chase_count_nxt = '0;
      unique case (chase_phase_r)
        CH_B0:   chase_phase_nxt = CH_B1;
        CH_B1:   chase_phase_nxt = CH_B2;
        default: chase_phase_nxt = CH_B0;
      endcase
    end
    unique case (chase_phase_nxt)
      CH_B0:   chase_leds = 3'b001;
      CH_B1:   chase_leds = 3'b010;
      CH_B2:   chase_leds = 3'b100;
      default: chase_leds = 3'b000;
    endcase

    // blink
    if (blink_count_r < blink_limit_r) begin
      blink_count_nxt = blink_count_r + 1'b1;
      blink_phase_nxt = blink_phase_r;
    end else begin
      blink_count_nxt = '0;
      blink_phase_nxt = (blink_phase_r == LV_ON) ? LV_OFF : LV_ON;
    end
    blink_led = (blink_phase_nxt == LV_ON);

    // tone level reported is the one held before this tick's update
    tone_out = (tone_phase_r == LV_ON);
    if (tone_count_r < tone_period_r) begin
      tone_count_nxt = tone_count_r + 1'b1;
      tone_phase_nxt = tone_phase_r;
    end else begin
      tone_count_nxt = '0;
      tone_phase_nxt = (tone_phase_r == LV_OFF && held) ? LV_ON : LV_OFF;
    end

    // period adjust, up wins over down
    unique case (adjust_phase_r)
      AD_WAIT:     adjust_phase_nxt = up ? AD_INC : (down ? AD_DEC : AD_WAIT);
      AD_INC:      adjust_phase_nxt = AD_INC_WAIT;
      AD_INC_WAIT: adjust_phase_nxt = up ? AD_INC_WAIT : (down ? AD_DEC : AD_WAIT);
      AD_DEC:      adjust_phase_nxt = AD_DEC_WAIT;
      AD_DEC_WAIT: adjust_phase_nxt = up ? AD_INC : (down ? AD_DEC_WAIT : AD_WAIT);
      default:     adjust_phase_nxt = AD_WAIT;
    endcase
    tone_period_nxt = tone_period_r;
    if (adjust_phase_nxt == AD_INC) begin
      if (tone_period_r < PERIOD_MAX) tone_period_nxt = tone_period_r + 1'b1;
    end else if (adjust_phase_nxt == AD_DEC) begin
      if (tone_period_r > 8'd1) tone_period_nxt = tone_period_r - 1'b1;
    end

    out_data_nxt = {3'b000, tone_out, blink_led, chase_leds};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chase_limit_r  <= CHASE_LIMIT_RST;
      blink_limit_r  <= BLINK_LIMIT_RST;
      chase_count_r  <= '0;
      chase_phase_r  <= CH_START;
      blink_count_r  <= '0;
      blink_phase_r  <= LV_START;
      tone_count_r   <= '0;
      tone_phase_r   <= LV_START;
      tone_period_r  <= '0;
      adjust_phase_r <= AD_START;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_CHASE_LIMIT) chase_limit_r <= cfg_data;
        if (cfg_index == REG_BLINK_LIMIT) blink_limit_r <= cfg_data;
      end
      if (in_xfer) begin
        chase_count_r  <= chase_count_nxt;
        chase_phase_r  <= chase_phase_nxt;
        blink_count_r  <= blink_count_nxt;
        blink_phase_r  <= blink_phase_nxt;
        tone_count_r   <= tone_count_nxt;
        tone_phase_r   <= tone_phase_nxt;
        tone_period_r  <= tone_period_nxt;
        adjust_phase_r <= adjust_phase_nxt;
        out_valid_r    <= 1'b1;
      end else if (out_tready) begin
        out_valid_r    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule : led_chaser_tone_generator
`default_nettype wire

FILE: tb/sv/led_chaser_tone_generator_check.sv
// ---------------------------------------------------------------------------
// led_chaser_tone_generator_check
// Watches the tick, result and register channels of the chaser block. Keeps
// its own copy of the chaser, blink, tone and period state, and compares
// each result transfer field by field against the oldest predicted output.
// ---------------------------------------------------------------------------
module led_chaser_tone_generator_check import lctg_pkg::*; (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_tvalid,
  input  wire                   in_tready,
  input  wire  [IN_DATA_W-1:0]  in_tdata,   // [0] up, [1] down, [2] tone button
  input  wire                   out_tvalid,
  input  wire                   out_tready,
  input  wire  [OUT_DATA_W-1:0] out_tdata,  // [2:0] chase, [3] blink, [4] tone
  input  wire                   cfg_valid,
  input  wire                   cfg_ready,
  input  wire  [CFG_IDX_W-1:0]  cfg_index,
  input  wire  [LIMIT_W-1:0]    cfg_data,
  output int                    errors,
  output int                    pending,
  output int                    peak_period
);

  typedef struct packed {
    logic [2:0] leds;
    logic       blink;
    logic       tone;
  } lamps_t;

  logic [LIMIT_W-1:0]  chase_lim, blink_lim;
  logic [LIMIT_W-1:0]  chase_cnt, blink_cnt;
  chase_phase_t        chase_ph;
  logic [2:0]          chase_pat;
  level_phase_t        blink_ph, tone_ph;
  logic                blink_lvl, tone_lvl;
  logic [PERIOD_W-1:0] tone_cnt, period;
  adjust_phase_t       adj_ph;

  lamps_t lamps_due[$];
  lamps_t want, got;

  initial begin
    errors      = 0;
    pending     = 0;
    peak_period = 0;
  end

  // One tick: chaser, blink, latch outputs, tone, then period adjust.
  function automatic lamps_t advance_tick(input logic up, input logic down,
                                          input logic held);
    lamps_t r;
    if (chase_cnt < chase_lim) begin
      chase_cnt = chase_cnt + 1'b1;
    end else begin
      case (chase_ph)
        CH_B0: begin
          chase_ph  = CH_B1;
          chase_pat = 3'b010;
        end
        CH_B1: begin
          chase_ph  = CH_B2;
          chase_pat = 3'b100;
        end
        default: begin
          chase_ph  = CH_B0;
          chase_pat = 3'b001;
        end
      endcase
      chase_cnt = '0;
    end

    if (blink_cnt < blink_lim) begin
      blink_cnt = blink_cnt + 1'b1;
    end else begin
      if (blink_ph == LV_ON) begin
        blink_ph  = LV_OFF;
        blink_lvl = 1'b0;
      end else begin
        blink_ph  = LV_ON;
        blink_lvl = 1'b1;
      end
      blink_cnt = '0;
    end

    r.leds  = chase_pat;
    r.blink = blink_lvl;
    r.tone  = tone_lvl;

    if (tone_cnt < period) begin
      tone_cnt = tone_cnt + 1'b1;
    end else begin
      if (tone_ph == LV_OFF && held) begin
        tone_ph  = LV_ON;
        tone_lvl = 1'b1;
      end else begin
        tone_ph  = LV_OFF;
        tone_lvl = 1'b0;
      end
      tone_cnt = '0;
    end

    // up wins over down everywhere
    case (adj_ph)
      AD_WAIT: begin
        if (up) adj_ph = AD_INC;
        else if (down) adj_ph = AD_DEC;
      end
      AD_INC: adj_ph = AD_INC_WAIT;
      AD_INC_WAIT: begin
        if (!up) adj_ph = down ? AD_DEC : AD_WAIT;
      end
      AD_DEC: adj_ph = AD_DEC_WAIT;
      AD_DEC_WAIT: begin
        if (up) adj_ph = AD_INC;
        else if (!down) adj_ph = AD_WAIT;
      end
      default: adj_ph = AD_WAIT;
    endcase
    if (adj_ph == AD_INC) begin
      if (period < PERIOD_MAX) period = period + 1'b1;
    end else if (adj_ph == AD_DEC) begin
      if (period > 1) period = period - 1'b1;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      chase_lim = CHASE_LIMIT_RST;
      blink_lim = BLINK_LIMIT_RST;
      chase_cnt = '0;
      chase_ph  = CH_START;
      chase_pat = '0;
      blink_cnt = '0;
      blink_ph  = LV_START;
      blink_lvl = 1'b0;
      tone_cnt  = '0;
      tone_ph   = LV_START;
      tone_lvl  = 1'b0;
      period    = '0;
      adj_ph    = AD_START;
      lamps_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CHASE_LIMIT: chase_lim = cfg_data;
          REG_BLINK_LIMIT: blink_lim = cfg_data;
          default: ;  // unknown index is dropped
        endcase
      end

      // results are registered behind their tick, so retire before predicting
      if (out_tvalid && out_tready) begin
        got.leds  = out_tdata[2:0];
        got.blink = out_tdata[3];
        got.tone  = out_tdata[4];
        if (lamps_due.size() == 0) begin
          errors++;
          $display("%0t: result transfer with nothing expected: got %h",
                   $time, out_tdata);
        end else begin
          want = lamps_due.pop_front();
          if (got.leds !== want.leds) begin
            errors++;
            $display("%0t: chase_leds expected %b, got %b", $time, want.leds, got.leds);
          end
          if (got.blink !== want.blink) begin
            errors++;
            $display("%0t: blink_led expected %b, got %b", $time, want.blink, got.blink);
          end
          if (got.tone !== want.tone) begin
            errors++;
            $display("%0t: tone_out expected %b, got %b", $time, want.tone, got.tone);
          end
          if (out_tdata[OUT_DATA_W-1:5] !== '0) begin
            errors++;
            $display("%0t: pad bits expected 0, got %b", $time,
                     out_tdata[OUT_DATA_W-1:5]);
          end
        end
      end

      if (in_tvalid && in_tready) begin
        lamps_due.push_back(advance_tick(in_tdata[0], in_tdata[1], in_tdata[2]));
        if (int'(period) > peak_period) peak_period = int'(period);
      end
    end
    pending = lamps_due.size();
  end

endmodule : led_chaser_tone_generator_check

FILE: tb/sv/led_chaser_tone_generator_test.sv
// ---------------------------------------------------------------------------
// led_chaser_tone_generator_test
// Drives button ticks and limit writes into the chaser block with random
// gaps and back-pressure; the checker beside the block predicts every result.
// ---------------------------------------------------------------------------
module led_chaser_tone_generator_test;
  import lctg_pkg::*;

  localparam int CYCLE_LIMIT = 300000;

  // button codes are {tone, down, up}; read left to right
  localparam int          TOUCH_CNT = 24;
  localparam logic [71:0] TOUCHES = {
    3'b000, 3'b010, 3'b010, 3'b010, 3'b000, 3'b001, 3'b001, 3'b001,
    3'b010, 3'b010, 3'b001, 3'b011, 3'b000, 3'b011, 3'b100, 3'b100,
    3'b110, 3'b110, 3'b100, 3'b101, 3'b111, 3'b111, 3'b000, 3'b100
  };

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // [0] up, [1] down, [2] tone button
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // [2:0] chase, [3] blink, [4] tone
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [LIMIT_W-1:0]    cfg_data;

  int errors;
  int pending;
  int peak_period;
  int cycles = 0;
  int ticks_sent = 0;
  int settings_used = 0;
  bit gaps_in;
  bit gaps_out;
  bit tone_hold;

  led_chaser_tone_generator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  led_chaser_tone_generator_check lamp_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .errors      (errors),
    .pending     (pending),
    .peak_period (peak_period)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding",
               cycles, pending);
      $display("Regression FAIL");
      $finish;
    end
  end

  // result side: a fresh stall before each result
  initial begin
    int stall;
    out_tready = 1'b0;
    forever begin
      stall = gaps_out ? $urandom_range(0, 11) : 0;
      @(negedge clk);
      out_tready <= (stall == 0);
      if (stall > 0) begin
        repeat (stall) @(negedge clk);
        out_tready <= 1'b1;
      end
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  task automatic send_tick(input logic [2:0] btn);
    int gap;
    gap = gaps_in ? $urandom_range(0, 11) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_DATA_W-3){1'b0}}, btn};
    do @(posedge clk); while (!in_tready);
    ticks_sent++;
  endtask

  // every tick yields one result, so an empty queue means the block is idle
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    wait (pending == 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [LIMIT_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [LIMIT_W-1:0] pick_limit();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 16'd1;
      2: return 16'd2;
      3: return 16'hFFFF;
      4: return 16'hFFFE;
      default: return LIMIT_W'($urandom_range(1, 12));
    endcase
  endfunction

  task automatic new_setting(input logic [LIMIT_W-1:0] chase,
                             input logic [LIMIT_W-1:0] blink);
    settle();
    write_reg(REG_CHASE_LIMIT, chase);
    write_reg(REG_BLINK_LIMIT, blink);
    // stray index, must leave both limits alone
    if ($urandom_range(0, 3) == 0)
      write_reg(CFG_IDX_W'(REG_BLINK_LIMIT + 1 + $urandom_range(0, 253)),
                LIMIT_W'($urandom));
    settings_used++;
    gaps_in  = ($urandom_range(0, 3) != 0);
    gaps_out = ($urandom_range(0, 3) != 0);
  endtask

  // hold a button pattern for a few ticks; tone button mostly follows tone_hold
  task automatic press(input logic up, input logic down, input int count,
                       inout int n);
    repeat (count) begin
      send_tick({tone_hold ^ ($urandom_range(0, 7) == 0), down, up});
      n++;
    end
  endtask

  task automatic play_gesture(inout int n);
    if ($urandom_range(0, 2) == 0) tone_hold = ~tone_hold;
    case ($urandom_range(0, 9))
      0, 1, 2: press(1'b1, 1'b0, $urandom_range(1, 3), n);
      3, 4, 5: press(1'b0, 1'b1, $urandom_range(1, 3), n);
      6: begin
        press(1'b1, 1'b0, $urandom_range(1, 3), n);
        press(1'b0, 1'b1, $urandom_range(1, 3), n);
      end
      7: begin
        press(1'b0, 1'b1, $urandom_range(1, 3), n);
        press(1'b1, 1'b0, $urandom_range(1, 3), n);
      end
      8: press(1'b1, 1'b1, $urandom_range(1, 3), n);
      default: begin
        repeat ($urandom_range(1, 4)) begin
          send_tick(3'($urandom));
          n++;
        end
      end
    endcase
    press(1'b0, 1'b0, $urandom_range(1, 2), n);
  endtask

  task automatic run_random(input int items);
    int n;
    n = 0;
    while (n < items) play_gesture(n);
  endtask

  initial begin
    int n;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    gaps_in   = 1'b0;
    gaps_out  = 1'b0;
    tone_hold = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: both LED machines step on every tick, walk the period machine
    new_setting('0, '0);
    for (int i = TOUCH_CNT - 1; i >= 0; i--) send_tick(TOUCHES[3*i +: 3]);

    // one limit widest and the other at 1, then swapped to cut chase below its count
    new_setting(16'hFFFF, 16'd1);
    run_random(60);
    new_setting(16'd1, 16'hFFFF);
    run_random(60);
    repeat (3) begin
      new_setting(pick_limit(), pick_limit());
      run_random(60);
    end

    // climb the tone period with single up presses; two idle ticks let the
    // period machine fall back to wait so every press after the first counts
    new_setting(pick_limit(), pick_limit());
    n = 0;
    repeat (50) begin
      press(1'b1, 1'b0, 1, n);
      press(1'b0, 1'b0, 2, n);
    end

    repeat (2) begin
      new_setting(pick_limit(), pick_limit());
      run_random(60);
    end

    settle();
    repeat (4) @(posedge clk);
    $display("Covered %0d ticks over %0d limit settings, with gaps and stalls on both sides.",
             ticks_sent, settings_used);
    $display("Tone period peaked at %0d; %0d mismatches seen.", peak_period, errors);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule : led_chaser_tone_generator_test

FILE: files.f
hw/rtl/lctg_pkg.sv
hw/rtl/led_chaser_tone_generator.sv
tb/sv/led_chaser_tone_generator_check.sv
tb/sv/led_chaser_tone_generator_test.sv
